// ===== hw/rtl/six_wheel_speed_from_turn_assert.svh =====
// assertion macros used by the top-level rtl file
`ifndef SIX_WHEEL_SPEED_FROM_TURN_ASSERT_SVH
`define SIX_WHEEL_SPEED_FROM_TURN_ASSERT_SVH
`ifndef SYNTHESIS
`define SWS_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`define SWS_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error("assertion failed");
`else
`define SWS_ASSERT(lbl, clk, rst_n, ante, cons)
`define SWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`define SWS_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons)
`endif
`endif

// ===== hw/rtl/swsft_pkg.sv =====
package swsft_pkg;

    // geometry and pipeline sizes
    localparam int SQ_STAGES  = 22;
    localparam int QBITS      = 17;
    localparam int DIV_LAT    = QBITS + 2;
    localparam int GEOM_LAT   = 5;
    localparam int PIPE_DEPTH = GEOM_LAT + SQ_STAGES + 1 + DIV_LAT + 1;

    // floor(2.3 * mag) as a multiply by 2.3 * 2^16, exact for mag <= 100
    localparam logic [17:0] RECIP_23_10 = 18'd150733;
    localparam logic [7:0]  RADIUS_BASE = 8'd250;
    localparam logic [7:0]  TURN_MAX    = 8'd100;

    typedef enum logic [1:0] {
        REG_D1 = 2'd0,
        REG_D2 = 2'd1,
        REG_D3 = 2'd2,
        REG_D4 = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [26:0]        s_fo;
        logic [26:0]        s_ro;
        logic [26:0]        s_fi;
        logic [26:0]        s_ri;
        logic [27:0]        mid_mag;
        logic               mid_neg;
        logic [12:0]        den;
        logic signed [7:0]  speed;
        logic               straight;
        logic               left;
    } geom_out_t;

    typedef struct packed {
        logic [27:0]        mid_mag;
        logic               mid_neg;
        logic [12:0]        den;
        logic signed [7:0]  speed;
        logic               straight;
        logic               left;
    } side_t;

    typedef struct packed {
        logic signed [7:0]  speed;
        logic               straight;
        logic               left;
    } tail_t;

endpackage

// ===== hw/rtl/swsft_geom.sv =====
module swsft_geom (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [7:0]       speed,
    input  logic signed [7:0]       turn,
    input  logic [11:0]             d1,
    input  logic [11:0]             d2,
    input  logic [11:0]             d3,
    input  logic [11:0]             d4,
    output logic                    out_valid,
    output swsft_pkg::geom_out_t    out_data
);

    logic [4:0] vld_reg;

    // stage 1: turn magnitude
    logic signed [7:0] spd1_reg;
    logic              zero1_reg;
    logic              left1_reg;
    logic [6:0]        mag1_reg;
    logic [7:0]        turn_abs;
    logic [6:0]        mag_next;

    // stage 2: radius in inches
    logic signed [7:0] spd2_reg;
    logic              zero2_reg;
    logic              left2_reg;
    logic [7:0]        rq2_reg;
    logic [24:0]       rad_prod;

    // stage 3: offsets
    logic signed [7:0] spd3_reg;
    logic              zero3_reg;
    logic              left3_reg;
    logic [12:0]       bo3_reg;
    logic [11:0]       bi3_reg;
    logic [12:0]       den3_reg;
    logic [11:0]       rm4_abs3_reg;
    logic              mid_neg3_reg;
    logic [7:0]        spd_abs3_reg;
    logic [11:0]       d2_3_reg;
    logic [11:0]       d3_3_reg;
    logic [11:0]       r3;
    logic [13:0]       bi_diff;
    logic [13:0]       rm4_diff;
    logic [13:0]       bi_abs;
    logic [13:0]       rm4_abs;

    // stage 4: squares
    logic signed [7:0] spd4_reg;
    logic              zero4_reg;
    logic              left4_reg;
    logic [25:0]       sq_bo4_reg;
    logic [23:0]       sq_bi4_reg;
    logic [23:0]       sq_d2_4_reg;
    logic [23:0]       sq_d3_4_reg;
    logic [19:0]       mid4_reg;
    logic              mid_neg4_reg;
    logic [12:0]       den4_reg;

    // stage 5: sums
    swsft_pkg::geom_out_t out_reg;

    assign turn_abs = turn[7] ? (8'd0 - 8'(turn)) : 8'(turn);
    assign mag_next = (turn_abs > swsft_pkg::TURN_MAX) ? 7'(swsft_pkg::TURN_MAX)
                                                       : turn_abs[6:0];
    assign rad_prod = 25'(mag1_reg) * 25'(swsft_pkg::RECIP_23_10);
    assign r3       = {rq2_reg, 4'b0000};
    assign bi_diff  = {2'b00, r3} - {2'b00, d1};
    assign rm4_diff = {2'b00, r3} - {2'b00, d4};
    assign bi_abs   = bi_diff[13] ? (14'd0 - bi_diff) : bi_diff;
    assign rm4_abs  = rm4_diff[13] ? (14'd0 - rm4_diff) : rm4_diff;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        spd1_reg  <= speed;
        zero1_reg <= (turn == 8'sd0);
        left1_reg <= turn[7];
        mag1_reg  <= mag_next;

        spd2_reg  <= spd1_reg;
        zero2_reg <= zero1_reg;
        left2_reg <= left1_reg;
        rq2_reg   <= swsft_pkg::RADIUS_BASE - rad_prod[23:16];

        spd3_reg     <= spd2_reg;
        zero3_reg    <= zero2_reg;
        left3_reg    <= left2_reg;
        bo3_reg      <= {1'b0, r3} + {1'b0, d1};
        bi3_reg      <= bi_abs[11:0];
        den3_reg     <= {1'b0, r3} + {1'b0, d4};
        rm4_abs3_reg <= rm4_abs[11:0];
        mid_neg3_reg <= spd2_reg[7] ^ rm4_diff[13];
        spd_abs3_reg <= spd2_reg[7] ? (8'd0 - 8'(spd2_reg)) : 8'(spd2_reg);
        d2_3_reg     <= d2;
        d3_3_reg     <= d3;

        spd4_reg     <= spd3_reg;
        zero4_reg    <= zero3_reg;
        left4_reg    <= left3_reg;
        sq_bo4_reg   <= 26'(bo3_reg) * 26'(bo3_reg);
        sq_bi4_reg   <= 24'(bi3_reg) * 24'(bi3_reg);
        sq_d2_4_reg  <= 24'(d2_3_reg) * 24'(d2_3_reg);
        sq_d3_4_reg  <= 24'(d3_3_reg) * 24'(d3_3_reg);
        mid4_reg     <= 20'(spd_abs3_reg) * 20'(rm4_abs3_reg);
        mid_neg4_reg <= mid_neg3_reg;
        den4_reg     <= den3_reg;

        out_reg.s_fo     <= 27'(sq_d3_4_reg) + 27'(sq_bo4_reg);
        out_reg.s_ro     <= 27'(sq_d2_4_reg) + 27'(sq_bo4_reg);
        out_reg.s_fi     <= 27'(sq_d3_4_reg) + 27'(sq_bi4_reg);
        out_reg.s_ri     <= 27'(sq_d2_4_reg) + 27'(sq_bi4_reg);
        out_reg.mid_mag  <= {mid4_reg, 8'h00};
        out_reg.mid_neg  <= mid_neg4_reg;
        out_reg.den      <= den4_reg;
        out_reg.speed    <= spd4_reg;
        out_reg.straight <= zero4_reg;
        out_reg.left     <= left4_reg;
    end

    assign out_valid = vld_reg[4];
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/swsft_sqrt.sv =====
module swsft_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [26:0] s_in,
    output logic        out_valid,
    output logic [21:0] root
);

    localparam int N = swsft_pkg::SQ_STAGES;

    logic [23:0] rem_reg  [N];
    logic [21:0] root_reg [N];
    logic [43:0] v_reg    [N];
    logic        vld_reg  [N];

    // one root bit per stage, radicand is s_in scaled by 2^16
    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam int P = N - 1 - k;
        logic [23:0] rem_p;
        logic [21:0] root_p;
        logic [43:0] v_p;
        logic        vld_p;
        logic [25:0] cand;
        logic [25:0] trial;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign v_p    = {1'b0, s_in, 16'h0000};
            assign vld_p  = in_valid;
        end
        else
        begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign v_p    = v_reg[k-1];
            assign vld_p  = vld_reg[k-1];
        end

        assign cand  = {rem_p, v_p[2*P+1:2*P]};
        assign trial = {2'b00, root_p, 2'b01};
        assign ge    = (cand >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_p;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? 24'(cand - trial) : cand[23:0];
            root_reg[k] <= {root_p[20:0], ge};
            v_reg[k]    <= v_p;
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];

endmodule

// ===== hw/rtl/swsft_div.sv =====
module swsft_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        neg,
    input  logic [29:0] mag,
    input  logic [12:0] den,
    output logic        out_valid,
    output logic [15:0] value,
    output logic        sat
);

    localparam int N = swsft_pkg::QBITS;

    // prep stage: rounding offset and overflow check
    logic        vld0_reg;
    logic [31:0] rem0_reg;
    logic [13:0] d2_0_reg;
    logic        ovf0_reg;
    logic        neg0_reg;
    logic [31:0] num_next;
    logic [13:0] d2_next;

    logic [31:0] rem_reg [N];
    logic [16:0] q_reg   [N];
    logic [13:0] d2_reg  [N];
    logic        ovf_reg [N];
    logic        neg_reg [N];
    logic        vld_reg [N];

    logic        vldf_reg;
    logic [15:0] val_reg;
    logic        sat_reg;
    logic [16:0] q_last;
    logic [15:0] val_next;
    logic        sat_next;

    assign num_next = {1'b0, mag, 1'b0} + {19'd0, den};
    assign d2_next  = {den, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vldf_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= in_valid;
            vldf_reg <= vld_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rem0_reg <= num_next;
        d2_0_reg <= d2_next;
        ovf0_reg <= (num_next[31:17] >= {1'b0, d2_next});
        neg0_reg <= neg;
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < N; j++)
    begin : g_stage
        localparam int B = N - 1 - j;
        logic [31:0] rem_p;
        logic [16:0] q_p;
        logic [13:0] d2_p;
        logic        ovf_p;
        logic        neg_p;
        logic        vld_p;
        logic [31:0] dsh;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign rem_p = rem0_reg;
            assign q_p   = '0;
            assign d2_p  = d2_0_reg;
            assign ovf_p = ovf0_reg;
            assign neg_p = neg0_reg;
            assign vld_p = vld0_reg;
        end
        else
        begin : g_next
            assign rem_p = rem_reg[j-1];
            assign q_p   = q_reg[j-1];
            assign d2_p  = d2_reg[j-1];
            assign ovf_p = ovf_reg[j-1];
            assign neg_p = neg_reg[j-1];
            assign vld_p = vld_reg[j-1];
        end

        assign dsh = {18'd0, d2_p} << B;
        assign ge  = (rem_p >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_p;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= ge ? (rem_p - dsh) : rem_p;
            q_reg[j]   <= q_p | (17'(ge) << B);
            d2_reg[j]  <= d2_p;
            ovf_reg[j] <= ovf_p;
            neg_reg[j] <= neg_p;
        end
    end

    // sign and clip to 16 bits
    assign q_last = q_reg[N-1];

    always_comb
    begin
        if (neg_reg[N-1])
        begin
            if (ovf_reg[N-1] || (q_last > 17'd32768))
            begin
                val_next = 16'h8000;
                sat_next = 1'b1;
            end
            else
            begin
                val_next = 16'(17'd0 - q_last);
                sat_next = 1'b0;
            end
        end
        else
        begin
            if (ovf_reg[N-1] || (q_last > 17'd32767))
            begin
                val_next = 16'h7fff;
                sat_next = 1'b1;
            end
            else
            begin
                val_next = q_last[15:0];
                sat_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        sat_reg <= sat_next;
    end

    assign out_valid = vldf_reg;
    assign value     = val_reg;
    assign sat       = sat_reg;

endmodule

// ===== hw/rtl/six_wheel_speed_from_turn.sv =====
// six wheel speed split: one command per cycle while busy is low
// throughput: one command every clock while busy is low; done pulses once per command, in order
// latency comes mostly from the 22-stage square root lanes and 19-stage dividers
// reset (rst_n low, asynchronous) clears geometry registers to zero and
// empties the pipeline; busy is high during reset and the following cycle
`include "six_wheel_speed_from_turn_assert.svh"

module six_wheel_speed_from_turn (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [7:0]  speed_cmd,
    input  logic signed [7:0]  turn_cmd,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] wheel_speed_0,
    output logic signed [15:0] wheel_speed_1,
    output logic signed [15:0] wheel_speed_2,
    output logic signed [15:0] wheel_speed_3,
    output logic signed [15:0] wheel_speed_4,
    output logic signed [15:0] wheel_speed_5,
    output logic               saturated
);

    localparam int SQ = swsft_pkg::SQ_STAGES;
    localparam int DL = swsft_pkg::DIV_LAT;

    logic        busy_reg;
    logic [11:0] d1_reg;
    logic [11:0] d2_reg;
    logic [11:0] d3_reg;
    logic [11:0] d4_reg;
    logic        accept;

    logic                 geom_vld;
    swsft_pkg::geom_out_t geom;

    logic [26:0] sq_in  [4];
    logic [21:0] sq_out [4];
    logic [3:0]  sq_vld;

    swsft_pkg::side_t side_reg [SQ];

    logic                 mul_vld_reg;
    logic [29:0]          num_reg [4];
    logic                 spd_neg_reg;
    swsft_pkg::side_t     mul_side_reg;
    logic [7:0]           spd_abs;

    logic [29:0] dv_mag [5];
    logic [4:0]  dv_neg;
    logic [15:0] dv_val [5];
    logic [4:0]  dv_sat;
    logic [4:0]  dv_vld;

    swsft_pkg::tail_t tail_reg [DL];
    swsft_pkg::tail_t tail;

    logic        done_reg;
    logic [15:0] w_reg [6];
    logic        sat_reg;
    logic [15:0] spd256;
    logic [15:0] vv [6];

    assign accept = start && !busy_reg;

    // busy only around reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // geometry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
            d3_reg <= '0;
            d4_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (swsft_pkg::cfg_idx_t'(cfg_index))
                swsft_pkg::REG_D1: d1_reg <= cfg_data;
                swsft_pkg::REG_D2: d2_reg <= cfg_data;
                swsft_pkg::REG_D3: d3_reg <= cfg_data;
                swsft_pkg::REG_D4: d4_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // radius, offsets and squared distances
    swsft_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .speed     (speed_cmd),
        .turn      (turn_cmd),
        .d1        (d1_reg),
        .d2        (d2_reg),
        .d3        (d3_reg),
        .d4        (d4_reg),
        .out_valid (geom_vld),
        .out_data  (geom)
    );

    // corner distances: front outer, rear outer, front inner, rear inner
    assign sq_in[0] = geom.s_fo;
    assign sq_in[1] = geom.s_ro;
    assign sq_in[2] = geom.s_fi;
    assign sq_in[3] = geom.s_ri;

    for (genvar i = 0; i < 4; i++)
    begin : g_sqrt
        swsft_sqrt u_sqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (geom_vld),
            .s_in      (sq_in[i]),
            .out_valid (sq_vld[i]),
            .root      (sq_out[i])
        );
    end

    // sideband alongside the square roots
    always_ff @(posedge clk)
    begin
        side_reg[0].mid_mag  <= geom.mid_mag;
        side_reg[0].mid_neg  <= geom.mid_neg;
        side_reg[0].den      <= geom.den;
        side_reg[0].speed    <= geom.speed;
        side_reg[0].straight <= geom.straight;
        side_reg[0].left     <= geom.left;
        for (int i = 1; i < SQ; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // speed times corner distance
    assign spd_abs = side_reg[SQ-1].speed[7] ? (8'd0 - 8'(side_reg[SQ-1].speed))
                                             : 8'(side_reg[SQ-1].speed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= sq_vld[0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            num_reg[i] <= 30'(spd_abs) * 30'(sq_out[i]);
        end
        spd_neg_reg  <= side_reg[SQ-1].speed[7];
        mul_side_reg <= side_reg[SQ-1];
    end

    // rounding dividers, four corners and the inner middle wheel
    for (genvar i = 0; i < 4; i++)
    begin : g_num
        assign dv_mag[i] = num_reg[i];
        assign dv_neg[i] = spd_neg_reg;
    end
    assign dv_mag[4] = {2'b00, mul_side_reg.mid_mag};
    assign dv_neg[4] = mul_side_reg.mid_neg;

    for (genvar i = 0; i < 5; i++)
    begin : g_div
        swsft_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (mul_vld_reg),
            .neg       (dv_neg[i]),
            .mag       (dv_mag[i]),
            .den       (mul_side_reg.den),
            .out_valid (dv_vld[i]),
            .value     (dv_val[i]),
            .sat       (dv_sat[i])
        );
    end

    // sideband alongside the dividers
    always_ff @(posedge clk)
    begin
        tail_reg[0].speed    <= mul_side_reg.speed;
        tail_reg[0].straight <= mul_side_reg.straight;
        tail_reg[0].left     <= mul_side_reg.left;
        for (int i = 1; i < DL; i++)
        begin
            tail_reg[i] <= tail_reg[i-1];
        end
    end

    assign tail   = tail_reg[DL-1];
    assign spd256 = {tail.speed, 8'h00};

    // wheel order for a right turn
    assign vv[0] = dv_val[0];
    assign vv[1] = spd256;
    assign vv[2] = dv_val[1];
    assign vv[3] = dv_val[2];
    assign vv[4] = dv_val[4];
    assign vv[5] = dv_val[3];

    // result register and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.straight)
        begin
            for (int i = 0; i < 6; i++)
            begin
                w_reg[i] <= spd256;
            end
            sat_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                w_reg[i] <= tail.left ? vv[(i + 3) % 6] : vv[i];
            end
            sat_reg <= |dv_sat;
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign wheel_speed_0 = w_reg[0];
    assign wheel_speed_1 = w_reg[1];
    assign wheel_speed_2 = w_reg[2];
    assign wheel_speed_3 = w_reg[3];
    assign wheel_speed_4 = w_reg[4];
    assign wheel_speed_5 = w_reg[5];
    assign saturated     = sat_reg;

    // every transfer in gives exactly one result at fixed latency
    `SWS_ASSERT_DLY(a_latency, clk, rst_n, start && !busy, swsft_pkg::PIPE_DEPTH, done)
    `SWS_ASSERT(a_origin, clk, rst_n, done, $past(start && !busy, swsft_pkg::PIPE_DEPTH))
    // straight drive never clips
    `SWS_ASSERT_NXT(a_straight, clk, rst_n, dv_vld[0] && tail.straight, !saturated)
    // parallel lanes stay in step
    `SWS_ASSERT(a_lanes, clk, rst_n, dv_vld[0] || sq_vld[0], (dv_vld == {5{dv_vld[0]}}) && (sq_vld == {4{sq_vld[0]}}))

endmodule

// ===== tb/sv/wheel_speed_checker.sv =====
`timescale 1ns / 1ps

module wheel_speed_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [7:0]  speed_cmd,
    input  logic signed [7:0]  turn_cmd,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               done,
    input  logic signed [15:0] wheel_speed_0,
    input  logic signed [15:0] wheel_speed_1,
    input  logic signed [15:0] wheel_speed_2,
    input  logic signed [15:0] wheel_speed_3,
    input  logic signed [15:0] wheel_speed_4,
    input  logic signed [15:0] wheel_speed_5,
    input  logic               saturated,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [5:0][15:0] wheel;
        logic             clipped;
    } wheel_set_t;

    // geometry copy, sixteenths of an inch
    logic [11:0] corner_lat;
    logic [11:0] rear_dist;
    logic [11:0] front_dist;
    logic [11:0] mid_lat;

    wheel_set_t wheel_sets_due[$];
    int         mismatches;

    function automatic longint isqrt(longint val);
        longint root;
        longint bitv;
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > val)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (val >= root + bitv)
            begin
                val  = val - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // nearest, ties away from zero, den positive
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint wheel_at(longint spd, longint a, longint b, longint den);
        return round_div(spd * isqrt((a * a + b * b) << 16), den);
    endfunction

    function automatic wheel_set_t predict_wheels(logic signed [7:0] spd_in,
                                                  logic signed [7:0] trn_in);
        wheel_set_t res;
        longint     spd;
        longint     trn;
        longint     mag;
        longint     rad;
        longint     den;
        longint     d1;
        longint     d2;
        longint     d3;
        longint     d4;
        longint     side[6];
        longint     w[6];
        spd = spd_in;
        trn = trn_in;
        res.clipped = 1'b0;
        if (trn == 0)
        begin
            for (int i = 0; i < 6; i++)
                w[i] = spd * 256;
        end
        else
        begin
            d1  = corner_lat;
            d2  = rear_dist;
            d3  = front_dist;
            d4  = mid_lat;
            mag = (trn < 0) ? -trn : trn;
            if (mag > 100)
                mag = 100;
            rad = 16 * (250 - (230 * mag) / 100);
            den = rad + d4;
            side[0] = wheel_at(spd, d3, rad + d1, den);
            side[1] = spd * 256;
            side[2] = wheel_at(spd, d2, rad + d1, den);
            side[3] = wheel_at(spd, d3, rad - d1, den);
            side[4] = round_div(spd * 256 * (rad - d4), den);
            side[5] = wheel_at(spd, d2, rad - d1, den);
            // left turn swaps the outer and inner triples
            for (int i = 0; i < 6; i++)
                w[i] = (trn > 0) ? side[i] : side[(i + 3) % 6];
        end
        for (int i = 0; i < 6; i++)
        begin
            if (w[i] > 32767)
            begin
                w[i] = 32767;
                res.clipped = 1'b1;
            end
            if (w[i] < -32768)
            begin
                w[i] = -32768;
                res.clipped = 1'b1;
            end
            res.wheel[i] = w[i][15:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // watch config writes, command transfers and result strobes
    always @(posedge clk or negedge rst_n)
    begin : watch
        wheel_set_t        want;
        logic [5:0][15:0]  got;
        if (!rst_n)
        begin
            corner_lat <= '0;
            rear_dist  <= '0;
            front_dist <= '0;
            mid_lat    <= '0;
            wheel_sets_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (swsft_pkg::cfg_idx_t'(cfg_index))
                    swsft_pkg::REG_D1: corner_lat <= cfg_data;
                    swsft_pkg::REG_D2: rear_dist  <= cfg_data;
                    swsft_pkg::REG_D3: front_dist <= cfg_data;
                    swsft_pkg::REG_D4: mid_lat    <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                wheel_sets_due.push_back(predict_wheels(speed_cmd, turn_cmd));
            if (done)
            begin
                if (wheel_sets_due.size() == 0)
                    report_mismatch("unexpected result transfer", 1, 0);
                else
                begin
                    want = wheel_sets_due.pop_front();
                    got  = {wheel_speed_5, wheel_speed_4, wheel_speed_3,
                            wheel_speed_2, wheel_speed_1, wheel_speed_0};
                    for (int i = 0; i < 6; i++)
                        if (got[i] !== want.wheel[i])
                            report_mismatch($sformatf("wheel_speed_%0d", i),
                                            $signed(got[i]), $signed(want.wheel[i]));
                    if (saturated !== want.clipped)
                        report_mismatch("saturated", saturated, want.clipped);
                end
            end
        end
        fail_count <= mismatches;
        pending    <= wheel_sets_due.size();
    end

endmodule

// ===== tb/sv/tb_six_wheel_speed_from_turn.sv =====
`timescale 1ns / 1ps

module tb_six_wheel_speed_from_turn;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 60;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [7:0]  speed_cmd;
    logic signed [7:0]  turn_cmd;
    logic               cfg_wr_en;
    logic [1:0]         cfg_index;
    logic [11:0]        cfg_data;
    logic               done;
    logic signed [15:0] wheel_speed_0;
    logic signed [15:0] wheel_speed_1;
    logic signed [15:0] wheel_speed_2;
    logic signed [15:0] wheel_speed_3;
    logic signed [15:0] wheel_speed_4;
    logic signed [15:0] wheel_speed_5;
    logic               saturated;
    int                 fail_count;
    int                 pending;
    int                 quiet_cycles;
    int                 cmds_sent;
    int                 geom_sets;
    int                 idle_pct;

    six_wheel_speed_from_turn dut (.*);

    wheel_speed_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("tb_six_wheel_speed_from_turn failed");
            $finish;
        end
    end

    task automatic send_cmd(logic signed [7:0] spd, logic signed [7:0] trn);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        speed_cmd <= spd;
        turn_cmd  <= trn;
        do
            @(posedge clk);
        while (busy);
        cmds_sent++;
    endtask

    // hold off until every expected result has come back
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_geometry(logic [11:0] d1, logic [11:0] d2,
                                logic [11:0] d3, logic [11:0] d4);
        logic [11:0] vals[4];
        vals = '{d1, d2, d3, d4};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= swsft_pkg::cfg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        geom_sets++;
    endtask

    task automatic random_cmds(int count);
        logic signed [7:0] spd;
        logic signed [7:0] trn;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0:       trn = 8'sd0;
                1:       trn = 8'($urandom());
                2:       trn = $urandom_range(1) ? 8'sd100 : -8'sd100;
                default: trn = $signed(8'($urandom_range(200))) - 8'sd100;
            endcase
            if ($urandom_range(4) == 0)
                spd = 8'($urandom());
            else
                spd = $signed(8'($urandom_range(200))) - 8'sd100;
            send_cmd(spd, trn);
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        speed_cmd  <= '0;
        turn_cmd   <= '0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= swsft_pkg::REG_D1;
        cfg_data   <= '0;
        cmds_sent  = 0;
        geom_sets  = 0;
        idle_pct   = 16;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, both turn directions, clipping, inner wheel reversal
        set_geometry(12'd200, 12'd300, 12'd350, 12'd250);
        send_cmd(8'sd100, 8'sd0);
        send_cmd(-8'sd100, 8'sd0);
        send_cmd(8'sd0, 8'sd50);
        send_cmd(8'sd100, 8'sd1);
        send_cmd(8'sd100, -8'sd1);
        send_cmd(8'sd100, 8'sd100);
        send_cmd(8'sd100, -8'sd100);
        send_cmd(-8'sd100, 8'sd100);
        send_cmd(-8'sd100, -8'sd100);
        send_cmd(8'sd50, 8'sd127);
        send_cmd(8'sd50, -8'sd128);
        send_cmd(8'sd127, 8'sd0);
        send_cmd(-8'sd128, 8'sd0);
        send_cmd(8'sd127, 8'sd100);
        send_cmd(-8'sd128, -8'sd100);
        send_cmd(8'sd1, 8'sd33);
        send_cmd(-8'sd1, -8'sd67);
        drain();
        set_geometry(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_cmd(8'sd100, 8'sd100);
        send_cmd(-8'sd100, -8'sd100);
        send_cmd(8'sd127, 8'sd50);
        send_cmd(-8'sd128, -8'sd1);
        drain();

        // random phases over several geometry settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_geometry(12'd0, 12'd0, 12'd0, 12'd0);
                1: set_geometry(12'd4095, 12'd0, 12'd4095, 12'd0);
                2: set_geometry(12'd0, 12'd4095, 12'd0, 12'd4095);
                default: set_geometry(12'($urandom()), 12'($urandom()),
                                      12'($urandom()), 12'($urandom()));
            endcase
            idle_pct = (ph < 2) ? 16 : (ph < 4) ? 68 : 0;
            random_cmds(170);
            drain();
        end

        $display("covered %0d commands over %0d geometry settings", cmds_sent, geom_sets);
        if (fail_count == 0 && pending == 0)
            $display("tb_six_wheel_speed_from_turn passed");
        else
            $display("tb_six_wheel_speed_from_turn failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/swsft_pkg.sv
hw/rtl/swsft_geom.sv
hw/rtl/swsft_sqrt.sv
hw/rtl/swsft_div.sv
hw/rtl/six_wheel_speed_from_turn.sv
tb/sv/wheel_speed_checker.sv
tb/sv/tb_six_wheel_speed_from_turn.sv
